FILE: hw/rtl/dpc_pkg.sv
// shared types, constants and helpers for the direction pair compare block
// fixed-point formats: angles in degrees * 2^ANGLE_FRAC_BITS, trig in signed Q30
// no dependencies
`timescale 1ns / 1ps

package dpc_pkg;

  // angle scale, default CORDIC depth and lane count
  localparam int ANGLE_FRAC_BITS   = 8;
  localparam int CORDIC_STAGES_DEF = 18;
  localparam int LANES             = 3;

  // signed width of Q30 trig values and CORDIC registers
  localparam int Q_W = 34;
  // signed width of a wrapped angle in degrees
  localparam int D_W = 18;

  localparam logic signed [D_W-1:0] DEG_HALF = D_W'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [D_W-1:0] DEG_FULL = D_W'(360 << ANGLE_FRAC_BITS);
  localparam int DEG_LIM_INT = ((180 << ANGLE_FRAC_BITS) > 65535) ? 65535
                                                                  : (180 << ANGLE_FRAC_BITS);
  localparam logic [15:0] DEG_LIM = 16'(DEG_LIM_INT);
  localparam logic [15:0] OUT_MAX = 16'hFFFF;

  // degrees to radians: round(deg * K / 2^(F+2))
  localparam logic signed [27:0] DEG2RAD_K = 28'sd74961321;
  localparam int RPROD_W = D_W + 28;
  // radians to degrees: round(rad * K / 2^(54-F))
  localparam logic [29:0] RAD2DEG_K = 30'd961263668;

  localparam logic signed [Q_W-1:0] ONE_Q30     = Q_W'(64'sd1073741824);
  localparam logic signed [Q_W-1:0] NEG_ONE_Q30 = -ONE_Q30;
  localparam logic signed [Q_W-1:0] PI_Q30      = Q_W'(64'sd3373259426);
  localparam logic signed [Q_W-1:0] HALF_PI_Q30 = Q_W'(64'sd1686629713);
  localparam logic signed [Q_W-1:0] NEG_HALF_PI = -HALF_PI_Q30;
  localparam logic signed [Q_W-1:0] CORDIC_GAIN = Q_W'(64'sd652032874);
  localparam logic signed [2*Q_W-1:0] Q_RND     = (2*Q_W)'(1) <<< 29;

  typedef struct packed {
    logic [15:0] zenith_a;
    logic [15:0] zenith_b;
    logic [16:0] azimuth_a;
    logic [16:0] azimuth_b;
  } in_word_t;

  typedef struct packed {
    logic [15:0] opening_angle;
    logic [15:0] projected_error;
  } out_word_t;

  // rounded Q30 product, floor shift
  function automatic logic signed [Q_W-1:0] qmul(input logic signed [Q_W-1:0] a,
                                                 input logic signed [Q_W-1:0] b);
    logic signed [2*Q_W-1:0] p;
    p = a * b;
    p = p + Q_RND;
    return p[Q_W+29:30];
  endfunction

  // round(atan(2^-i) * 2^30)
  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      5'd26: v = 30'd16;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      5'd30: v = 30'd1;
      5'd31: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/dpc_sincos.sv
// pipelined rotation-mode CORDIC, sin and cos for several angle lanes at once
// one stage per iteration, quadrant fold in front, sign fix at the end
// depends on dpc_pkg
`timescale 1ns / 1ps

module dpc_sincos #(
  parameter int STAGES = dpc_pkg::CORDIC_STAGES_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic signed [dpc_pkg::Q_W-1:0]    in_ang [dpc_pkg::LANES],
  input  logic [SIDE_W-1:0]                 in_side,
  output logic                              out_vld,
  output logic signed [dpc_pkg::Q_W-1:0]    out_sin [dpc_pkg::LANES],
  output logic signed [dpc_pkg::Q_W-1:0]    out_cos [dpc_pkg::LANES],
  output logic [SIDE_W-1:0]                 out_side
);
  import dpc_pkg::*;

  logic [STAGES+1:0]       vld_r;
  logic [SIDE_W-1:0]       side_r [STAGES+2];
  logic signed [Q_W-1:0]   x_r [STAGES+1][LANES];
  logic signed [Q_W-1:0]   y_r [STAGES+1][LANES];
  logic signed [Q_W-1:0]   z_r [STAGES+1][LANES];
  logic                    neg_r [STAGES+1][LANES];
  logic signed [Q_W-1:0]   sin_r [LANES];
  logic signed [Q_W-1:0]   cos_r [LANES];

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STAGES:0], in_vld};
    end
  end

  // fold the angle into -pi/2..pi/2
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        x_r[0][l] <= CORDIC_GAIN;
        y_r[0][l] <= '0;
        if (in_ang[l] > HALF_PI_Q30) begin
          z_r[0][l]   <= in_ang[l] - PI_Q30;
          neg_r[0][l] <= 1'b1;
        end else if (in_ang[l] < NEG_HALF_PI) begin
          z_r[0][l]   <= in_ang[l] + PI_Q30;
          neg_r[0][l] <= 1'b1;
        end else begin
          z_r[0][l]   <= in_ang[l];
          neg_r[0][l] <= 1'b0;
        end
      end
      side_r[0] <= in_side;
    end
  end

  // rotation iterations
  for (genvar g = 0; g < STAGES; g++) begin : g_iter
    localparam logic signed [Q_W-1:0] ATAN_G = $signed({{(Q_W-30){1'b0}}, atan_q30(5'(g))});

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          if (z_r[g][l] >= 0) begin
            x_r[g+1][l] <= x_r[g][l] - (y_r[g][l] >>> g);
            y_r[g+1][l] <= y_r[g][l] + (x_r[g][l] >>> g);
            z_r[g+1][l] <= z_r[g][l] - ATAN_G;
          end else begin
            x_r[g+1][l] <= x_r[g][l] + (y_r[g][l] >>> g);
            y_r[g+1][l] <= y_r[g][l] - (x_r[g][l] >>> g);
            z_r[g+1][l] <= z_r[g][l] + ATAN_G;
          end
          neg_r[g+1][l] <= neg_r[g][l];
        end
        side_r[g+1] <= side_r[g];
      end
    end
  end

  // undo the fold
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        cos_r[l] <= neg_r[STAGES][l] ? -x_r[STAGES][l] : x_r[STAGES][l];
        sin_r[l] <= neg_r[STAGES][l] ? -y_r[STAGES][l] : y_r[STAGES][l];
      end
      side_r[STAGES+1] <= side_r[STAGES];
    end
  end

  assign out_vld  = vld_r[STAGES+1];
  assign out_sin  = sin_r;
  assign out_cos  = cos_r;
  assign out_side = side_r[STAGES+1];

endmodule

FILE: hw/rtl/dpc_isqrt.sv
// pipelined integer floor square root, one result bit per stage
// W-bit unsigned argument, W/2-bit root, sideband carried alongside
// no package dependency
`timescale 1ns / 1ps

module dpc_isqrt #(
  parameter int W      = 36,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [W-1:0]      in_val,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [W/2-1:0]    out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int N = W / 2;

  logic [N:0]        vld_r;
  logic [W-1:0]      rem_r [N+1];
  logic [W-1:0]      res_r [N+1];
  logic [SIDE_W-1:0] side_r [N+1];

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-1:0], in_vld};
    end
  end

  // capture argument
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= in_val;
      res_r[0]  <= '0;
      side_r[0] <= in_side;
    end
  end

  // one trial subtract per stage, from the top power of four down
  for (genvar g = 0; g < N; g++) begin : g_bit
    localparam logic [W:0] BIT = (W+1)'(1) << (W - 2 - 2*g);
    logic [W:0] trial;

    assign trial = {1'b0, res_r[g]} + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem_r[g]} >= trial) begin
          rem_r[g+1] <= W'({1'b0, rem_r[g]} - trial);
          res_r[g+1] <= W'(({1'b0, res_r[g]} >> 1) + BIT);
        end else begin
          rem_r[g+1] <= rem_r[g];
          res_r[g+1] <= res_r[g] >> 1;
        end
        side_r[g+1] <= side_r[g];
      end
    end
  end

  assign out_vld  = vld_r[N];
  assign out_root = res_r[N][N-1:0];
  assign out_side = side_r[N];

endmodule

FILE: hw/rtl/dpc_acos.sv
// pipelined vectoring-mode CORDIC giving acos from a cosine and its sine
// one stage per iteration, half-plane swap in front, clamp at zero at the end
// depends on dpc_pkg
`timescale 1ns / 1ps

module dpc_acos #(
  parameter int STAGES = dpc_pkg::CORDIC_STAGES_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic signed [31:0]     in_cos,
  input  logic [30:0]            in_sin,
  input  logic [SIDE_W-1:0]      in_side,
  output logic                   out_vld,
  output logic [31:0]            out_rad,
  output logic [SIDE_W-1:0]      out_side
);
  import dpc_pkg::*;

  logic [STAGES+1:0]     vld_r;
  logic [SIDE_W-1:0]     side_r [STAGES+2];
  logic signed [Q_W-1:0] x_r [STAGES+1];
  logic signed [Q_W-1:0] y_r [STAGES+1];
  logic signed [Q_W-1:0] z_r [STAGES+1];
  logic [31:0]           rad_r;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STAGES:0], in_vld};
    end
  end

  // negative cosine: rotate the vector by a quarter turn first
  always_ff @(posedge clk) begin
    if (en) begin
      if (in_cos < 0) begin
        x_r[0] <= $signed(Q_W'(in_sin));
        y_r[0] <= -Q_W'(in_cos);
        z_r[0] <= HALF_PI_Q30;
      end else begin
        x_r[0] <= Q_W'(in_cos);
        y_r[0] <= $signed(Q_W'(in_sin));
        z_r[0] <= '0;
      end
      side_r[0] <= in_side;
    end
  end

  // vectoring iterations drive y toward zero
  for (genvar g = 0; g < STAGES; g++) begin : g_iter
    localparam logic signed [Q_W-1:0] ATAN_G = $signed({{(Q_W-30){1'b0}}, atan_q30(5'(g))});

    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[g] > 0) begin
          x_r[g+1] <= x_r[g] + (y_r[g] >>> g);
          y_r[g+1] <= y_r[g] - (x_r[g] >>> g);
          z_r[g+1] <= z_r[g] + ATAN_G;
        end else begin
          x_r[g+1] <= x_r[g] - (y_r[g] >>> g);
          y_r[g+1] <= y_r[g] + (x_r[g] >>> g);
          z_r[g+1] <= z_r[g] - ATAN_G;
        end
        side_r[g+1] <= side_r[g];
      end
    end
  end

  // clamp at zero
  always_ff @(posedge clk) begin
    if (en) begin
      rad_r            <= (z_r[STAGES] < 0) ? '0 : z_r[STAGES][31:0];
      side_r[STAGES+1] <= side_r[STAGES];
    end
  end

  assign out_vld  = vld_r[STAGES+1];
  assign out_rad  = rad_r;
  assign out_side = side_r[STAGES+1];

endmodule

FILE: hw/rtl/direction_pair_compare_top.sv
// Throughput: one word per cycle while the output is not stalled; every step is its
// own register stage, the two square roots take one root bit per stage and the
// CORDICs one iteration per stage.
// A stalled output freezes the whole pipeline and the input stalls with it.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
// depends on dpc_pkg, dpc_sincos, dpc_isqrt, dpc_acos
`timescale 1ns / 1ps

module direction_pair_compare_top #(
  parameter int CORDIC_STAGES = dpc_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dpc_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dpc_pkg::out_word_t out_data
);
  import dpc_pkg::*;

  localparam int F = ANGLE_FRAC_BITS;
  localparam int SC_SIDE_W = D_W + 17;
  localparam logic signed [RPROD_W-1:0] RAD_RND = RPROD_W'(1) <<< (F + 1);
  localparam logic [61:0] DEG_RND = 62'(1) << (53 - F);
  localparam logic [60:0] ONE_SQ  = 61'(1) << 60;

  logic en;

  // whole pipeline moves unless a finished word is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: wrap angles, azimuth and zenith differences
  logic signed [D_W-1:0] za_ext, zb_ext, adiff, amod, wza_nxt, wzb_nxt, dphi_nxt;
  logic signed [16:0]    thr_nxt;
  logic                  s1_vld_r;
  logic signed [D_W-1:0] s1_wza_r, s1_wzb_r, s1_dphi_r;
  logic signed [16:0]    s1_thr_r;

  always_comb begin
    za_ext   = $signed(D_W'(in_data.zenith_a));
    zb_ext   = $signed(D_W'(in_data.zenith_b));
    wza_nxt  = (za_ext > DEG_HALF) ? za_ext - DEG_FULL : za_ext;
    wzb_nxt  = (zb_ext > DEG_HALF) ? zb_ext - DEG_FULL : zb_ext;
    adiff    = $signed(D_W'(in_data.azimuth_b)) - $signed(D_W'(in_data.azimuth_a));
    amod     = (adiff < 0) ? adiff + DEG_FULL : adiff;
    dphi_nxt = (amod > DEG_HALF) ? amod - DEG_FULL : amod;
    thr_nxt  = $signed(17'(in_data.zenith_b)) - $signed(17'(in_data.zenith_a));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_wza_r  <= wza_nxt;
      s1_wzb_r  <= wzb_nxt;
      s1_dphi_r <= dphi_nxt;
      s1_thr_r  <= thr_nxt;
    end
  end

  // stage 2: degrees to radians products
  logic                      s2_vld_r;
  logic signed [RPROD_W-1:0] s2_rprod_r [LANES];
  logic signed [D_W-1:0]     s2_dphi_r;
  logic signed [16:0]        s2_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_rprod_r[0] <= s1_wza_r * DEG2RAD_K;
      s2_rprod_r[1] <= s1_wzb_r * DEG2RAD_K;
      s2_rprod_r[2] <= s1_dphi_r * DEG2RAD_K;
      s2_dphi_r     <= s1_dphi_r;
      s2_thr_r      <= s1_thr_r;
    end
  end

  // rounded radians into the sin/cos pipeline
  logic signed [RPROD_W-1:0] rsum [LANES];
  logic signed [Q_W-1:0]     sc_ang [LANES];
  logic                      sc_vld;
  logic signed [Q_W-1:0]     sc_sin [LANES];
  logic signed [Q_W-1:0]     sc_cos [LANES];
  logic [SC_SIDE_W-1:0]      sc_side;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rsum[l]   = s2_rprod_r[l] + RAD_RND;
      sc_ang[l] = $signed(rsum[l][F+2+Q_W-1:F+2]);
    end
  end

  dpc_sincos #(
    .STAGES (CORDIC_STAGES),
    .SIDE_W (SC_SIDE_W)
  ) u_sincos (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s2_vld_r),
    .in_ang   (sc_ang),
    .in_side  ({s2_dphi_r, s2_thr_r}),
    .out_vld  (sc_vld),
    .out_sin  (sc_sin),
    .out_cos  (sc_cos),
    .out_side (sc_side)
  );

  // stage 3: first products of the dot product and scaled azimuth
  logic signed [Q_W-1:0] phr_full;
  logic                  s3_vld_r;
  logic signed [Q_W-1:0] s3_p1_r, s3_p2_r, s3_cd_r;
  logic signed [D_W-1:0] s3_phr_r;
  logic signed [16:0]    s3_thr_r;

  assign phr_full = qmul(sc_sin[0], Q_W'($signed(sc_side[SC_SIDE_W-1:17])));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= sc_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_p1_r  <= qmul(sc_cos[0], sc_cos[1]);
      s3_p2_r  <= qmul(sc_sin[0], sc_sin[1]);
      s3_cd_r  <= sc_cos[2];
      s3_phr_r <= phr_full[D_W-1:0];
      s3_thr_r <= $signed(sc_side[16:0]);
    end
  end

  // stage 4: third product and the two squares
  logic signed [2*D_W-1:0] phr_sq;
  logic signed [33:0]      thr_sq;
  logic                    s4_vld_r;
  logic signed [Q_W-1:0]   s4_p1_r, s4_p3_r;
  logic [35:0]             s4_phr2_r;
  logic [33:0]             s4_thr2_r;

  assign phr_sq = s3_phr_r * s3_phr_r;
  assign thr_sq = s3_thr_r * s3_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_p1_r   <= s3_p1_r;
      s4_p3_r   <= qmul(s3_p2_r, s3_cd_r);
      s4_phr2_r <= $unsigned(phr_sq);
      s4_thr2_r <= $unsigned(thr_sq);
    end
  end

  // stage 5: clamp the dot product, sum of squares
  logic signed [Q_W:0]   dot_sum;
  logic signed [Q_W-1:0] dot_clamp;
  logic                  s5_vld_r;
  logic signed [31:0]    s5_d_r;
  logic [35:0]           s5_esq_r;

  always_comb begin
    dot_sum = (Q_W+1)'(s4_p1_r) + (Q_W+1)'(s4_p3_r);
    if (dot_sum > (Q_W+1)'(ONE_Q30)) begin
      dot_clamp = ONE_Q30;
    end else if (dot_sum < (Q_W+1)'(NEG_ONE_Q30)) begin
      dot_clamp = NEG_ONE_Q30;
    end else begin
      dot_clamp = dot_sum[Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_d_r   <= dot_clamp[31:0];
      s5_esq_r <= 36'(s4_phr2_r) + 36'(s4_thr2_r);
    end
  end

  // error magnitude root, dot product rides along
  logic        er_vld;
  logic [17:0] er_root;
  logic [31:0] er_side;

  dpc_isqrt #(
    .W      (36),
    .SIDE_W (32)
  ) u_err_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s5_vld_r),
    .in_val   (s5_esq_r),
    .in_side  (s5_d_r),
    .out_vld  (er_vld),
    .out_root (er_root),
    .out_side (er_side)
  );

  // stage 6: saturate error, square the cosine
  logic signed [63:0] d_sq;
  logic               s6_vld_r;
  logic [15:0]        s6_err_r;
  logic [60:0]        s6_dd_r;
  logic signed [31:0] s6_d_r;

  assign d_sq = $signed(er_side) * $signed(er_side);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s6_vld_r <= er_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_err_r <= (er_root > 18'(OUT_MAX)) ? OUT_MAX : er_root[15:0];
      s6_dd_r  <= d_sq[60:0];
      s6_d_r   <= $signed(er_side);
    end
  end

  // stage 7: one minus cos squared
  logic               s7_vld_r;
  logic [61:0]        s7_v_r;
  logic signed [31:0] s7_d_r;
  logic [15:0]        s7_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else if (en) begin
      s7_vld_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_v_r   <= {1'b0, ONE_SQ - s6_dd_r};
      s7_d_r   <= s6_d_r;
      s7_err_r <= s6_err_r;
    end
  end

  // sine from the root of one minus cos squared
  logic        sn_vld;
  logic [30:0] sn_root;
  logic [47:0] sn_side;

  dpc_isqrt #(
    .W      (62),
    .SIDE_W (48)
  ) u_sin_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s7_vld_r),
    .in_val   (s7_v_r),
    .in_side  ({s7_d_r, s7_err_r}),
    .out_vld  (sn_vld),
    .out_root (sn_root),
    .out_side (sn_side)
  );

  // arccosine
  logic        ac_vld;
  logic [31:0] ac_rad;
  logic [15:0] ac_err;

  dpc_acos #(
    .STAGES (CORDIC_STAGES),
    .SIDE_W (16)
  ) u_acos (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (sn_vld),
    .in_cos   ($signed(sn_side[47:16])),
    .in_sin   (sn_root),
    .in_side  (sn_side[15:0]),
    .out_vld  (ac_vld),
    .out_rad  (ac_rad),
    .out_side (ac_err)
  );

  // stage 8: radians to degrees product
  logic        s8_vld_r;
  logic [61:0] s8_prod_r;
  logic [15:0] s8_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_vld_r <= 1'b0;
    end else if (en) begin
      s8_vld_r <= ac_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_prod_r <= 62'(ac_rad) * 62'(RAD2DEG_K);
      s8_err_r  <= ac_err;
    end
  end

  // output word: round, clamp to the top of the angle range
  logic [61:0]  deg_sum;
  logic [F+7:0] deg_raw;
  out_word_t    out_nxt;
  logic         out_vld_r;
  out_word_t    out_data_r;

  always_comb begin
    deg_sum                 = s8_prod_r + DEG_RND;
    deg_raw                 = deg_sum[61:54-F];
    out_nxt.opening_angle   = (deg_raw > (F+8)'(DEG_LIM)) ? DEG_LIM : 16'(deg_raw);
    out_nxt.projected_error = s8_err_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= s8_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // opening angle never leaves its range
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.opening_angle <= DEG_LIM))
    else $error("opening angle above limit");

  // clamped cosine stays within plus or minus one
  a_dot_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    s5_vld_r |-> ((s5_d_r <= 32'(ONE_Q30)) && (s5_d_r >= 32'(NEG_ONE_Q30))))
    else $error("dot product out of range after clamp");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule
